// ----- sv/bmp_pixel_unpacker_unit_assert.svh -----
// Assertion macros shared by the pixel unpacker RTL.
`ifndef BMP_PIXEL_UNPACKER_UNIT_ASSERT_SVH
`define BMP_PIXEL_UNPACKER_UNIT_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define BPU_ASSERT_SAME(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define BPU_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- sv/bpu_pkg.sv -----
// Shared types, constants and helpers of the BMP pixel unpacker.
`timescale 1ns / 1ps

package bpu_pkg;

    localparam int COLOR_W     = 24;
    localparam int COORD_W     = 12;
    localparam int SIZE_W      = 13;
    localparam int DEPTH_W     = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int PAL_DEPTH   = 256;
    localparam int PAL_ADDR_W  = $clog2(PAL_DEPTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int COUNT_W     = 4;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 48;

    localparam logic [SIZE_W-1:0] MAX_WIDTH  = 13'd4096;
    localparam logic [SIZE_W-1:0] MAX_HEIGHT = 13'd4096;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Depth codes that steer decoding
    localparam logic [DEPTH_W-1:0] DEPTH_8BPP  = 3'd3;
    localparam logic [DEPTH_W-1:0] DEPTH_24BPP = 3'd4;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 3'd5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd64;

    // Input word kinds
    localparam logic FUNC_PALETTE = 1'b0;
    localparam logic FUNC_PIXEL   = 1'b1;

    typedef enum logic [1:0] {
        ENT_PAL_WRITE,
        ENT_INDEXED,
        ENT_DIRECT
    } entry_kind_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_mode;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
    } bpu_cfg_t;

    // One classified word handed from the front to the back
    typedef struct packed {
        entry_kind_t         kind;
        logic [1:0]          depth_log;
        logic [COLOR_W-1:0]  color;
        logic [7:0]          code;
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  row;
        logic [COUNT_W-1:0]  count;
        logic                done;
    } bpu_entry_t;

    // Force a size into 1..bound
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] bound);
        logic [SIZE_W-1:0] r;
        r = v;
        if (r == '0) begin
            r = 13'd1;
        end
        if (r > bound) begin
            r = bound;
        end
        return r;
    endfunction

endpackage

// ----- sv/bmp_pixel_unpacker_unit.sv -----
// BMP pixel array unpacker: register file, front end, entry queue and back end.
`timescale 1ns / 1ps

// Takes one word per cycle on s_: a pixel-array byte (s_tuser = 1) or a palette
// write (s_tuser = 0), and returns one decoded pixel per cycle on m_ while m_tready
// holds. At 24 and 32 bits per pixel every third or fourth byte yields a pixel;
// padding bytes and palette writes yield nothing. At 1, 2, 4 or 8 bits per pixel
// a byte yields up to 8, 4, 2 or 1 pixels, emitted by the back-end sequencer one
// per cycle while m_tready holds, through the single palette read port, so the
// back end holds such a byte until all its pixels are out; a four-entry queue
// lets the input keep running meanwhile and stalls it only when full. The palette
// holds garbage after reset until written. Configuration is to be written by the
// user only while idle; the block itself does not enforce it.

module bmp_pixel_unpacker_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpu_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bpu_pkg::SIZE_W-1:0]        cfg_data,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bpu_pkg::S_TDATA_W-1:0]     s_tdata,  // data_byte, palette_index, palette_color
    input  logic                              s_tuser,  // func
    // decoded pixels
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bpu_pkg::M_TDATA_W-1:0]     m_tdata,  // pixel_color, pixel_column, pixel_row
    output logic                              m_tuser,  // last_of_byte
    output logic                              m_tlast   // image_done
);
    import bpu_pkg::*;

    logic [DEPTH_W-1:0] depth_mode_reg;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    bpu_cfg_t           cfg;

    logic               q_push_valid;
    logic               q_push_ready;
    bpu_entry_t         q_push_entry;
    logic               q_pop_valid;
    logic               q_pop_ready;
    bpu_entry_t         q_pop_entry;

    logic [COLOR_W-1:0] pixel_color;
    logic [COORD_W-1:0] pixel_column;
    logic [COORD_W-1:0] pixel_row;

    assign cfg_ready = 1'b1;

    // Hold configuration, sizes stored already clamped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_mode_reg <= DEPTH_RESET;
            width_reg      <= SIZE_RESET;
            height_reg     <= SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DEPTH_MODE:   depth_mode_reg <= cfg_data[DEPTH_W-1:0];
                REG_IMAGE_WIDTH:  width_reg      <= clamp_size(cfg_data, MAX_WIDTH);
                REG_IMAGE_HEIGHT: height_reg     <= clamp_size(cfg_data, MAX_HEIGHT);
                default:          ;
            endcase
        end
    end

    assign cfg.depth_mode = depth_mode_reg;
    assign cfg.width      = width_reg;
    assign cfg.height     = height_reg;

    bpu_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .func          (s_tuser),
        .data_byte     (s_tdata[7:0]),
        .palette_index (s_tdata[15:8]),
        .palette_color (s_tdata[39:16]),
        .push_valid    (q_push_valid),
        .push_ready    (q_push_ready),
        .push_entry    (q_push_entry)
    );

    bpu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_entry (q_push_entry),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_entry  (q_pop_entry)
    );

    bpu_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (q_pop_valid),
        .pop_ready    (q_pop_ready),
        .pop_entry    (q_pop_entry),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .pixel_color  (pixel_color),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .last_of_byte (m_tuser),
        .image_done   (m_tlast)
    );

    assign m_tdata = {pixel_row, pixel_column, pixel_color};

`include "bmp_pixel_unpacker_unit_assert.svh"

    // The last pixel of an image is always the last pixel of its byte
    `BPU_ASSERT_SAME(a_done_ends_byte, aclk, aresetn, m_tvalid && m_tlast, m_tuser,
                     "image end not at byte end")

    // Pixels of one byte follow back to back in adjacent columns
    `BPU_ASSERT_NEXT(a_byte_pixels_adjacent, aclk, aresetn,
                     m_tvalid && m_tready && !m_tuser,
                     m_tvalid && (m_tdata[35:24] == $past(m_tdata[35:24]) + 12'd1),
                     "byte pixels not contiguous")

    // A new image starts on row zero
    `BPU_ASSERT_NEXT(a_row_wraps, aclk, aresetn, m_tvalid && m_tready && m_tlast,
                     !m_tvalid || (m_tdata[47:36] == 12'd0),
                     "row did not wrap after image end")

endmodule

// ----- sv/bpu_front.sv -----
// Front end: accepts words, tracks row position and padding, builds queue entries.
`timescale 1ns / 1ps

module bpu_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bpu_pkg::bpu_cfg_t          cfg,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       func,
    input  logic [7:0]                 data_byte,
    input  logic [7:0]                 palette_index,
    input  logic [bpu_pkg::COLOR_W-1:0] palette_color,
    output logic                       push_valid,
    input  logic                       push_ready,
    output bpu_pkg::bpu_entry_t        push_entry
);
    import bpu_pkg::*;

    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [1:0]         rbc_reg, rbc_next;
    logic [1:0]         bip_reg, bip_next;
    logic [COLOR_W-1:0] gather_reg, gather_next;

    logic               accept;
    logic               sub_mode;
    logic [1:0]         depth_log;
    logic [COUNT_W-1:0] per_byte;
    logic [COUNT_W-1:0] step_px;
    logic [SIZE_W-1:0]  col_ext;
    logic [SIZE_W-1:0]  col_sum;
    logic [SIZE_W-1:0]  remaining;
    logic               row_end_px;
    logic               col_ge_w;
    logic [COUNT_W-1:0] sub_count;
    logic               deep_emit;
    logic [COLOR_W-1:0] shift_in;
    logic [COLOR_W-1:0] gathered;
    logic               emits;
    logic               row_end;
    logic               last_row;
    logic               done;
    logic               is_pad;

    assign accept  = s_valid && push_ready;
    assign s_ready = push_ready;

    // Classify the word and work out its pixels
    always_comb begin
        sub_mode   = (cfg.depth_mode <= DEPTH_8BPP);
        depth_log  = cfg.depth_mode[1:0];
        per_byte   = COUNT_W'(4'd8 >> depth_log);
        step_px    = sub_mode ? per_byte : COUNT_W'(1);
        col_ext    = {1'b0, col_reg};
        col_sum    = col_ext + SIZE_W'(step_px);
        remaining  = cfg.width - col_ext;
        row_end_px = (col_sum >= cfg.width);
        col_ge_w   = (col_ext >= cfg.width);
        if (!row_end_px) begin
            sub_count = per_byte;
        end else if (col_ge_w) begin
            sub_count = COUNT_W'(1);
        end else begin
            sub_count = remaining[COUNT_W-1:0];
        end
        deep_emit  = (cfg.depth_mode == DEPTH_24BPP) ? (bip_reg >= 2'd2) : (bip_reg == 2'd3);
        shift_in   = COLOR_W'(data_byte) << {bip_reg, 3'b000};
        gathered   = (bip_reg != 2'd3) ? (gather_reg | shift_in) : gather_reg;
        emits      = sub_mode || deep_emit;
        row_end    = emits && row_end_px;
        last_row   = (({1'b0, row_reg} + SIZE_W'(1)) >= cfg.height);
        done       = row_end && last_row;
        is_pad     = (col_reg == '0) && (bip_reg == '0) && (rbc_reg != '0);
    end

    // Advance position, padding and gather state
    always_comb begin
        col_next    = col_reg;
        row_next    = row_reg;
        rbc_next    = rbc_reg;
        bip_next    = bip_reg;
        gather_next = gather_reg;
        if (accept && func == FUNC_PIXEL) begin
            rbc_next = rbc_reg + 2'd1;
            if (!is_pad) begin
                if (!sub_mode) begin
                    if (deep_emit) begin
                        gather_next = '0;
                        bip_next    = '0;
                    end else begin
                        gather_next = gathered;
                        bip_next    = bip_reg + 2'd1;
                    end
                end
                if (emits) begin
                    if (row_end) begin
                        col_next = '0;
                        row_next = last_row ? '0 : row_reg + COORD_W'(1);
                    end else begin
                        col_next = col_sum[COORD_W-1:0];
                    end
                end
            end
        end
    end

    // Build the entry for the back end
    always_comb begin
        push_valid = s_valid && ((func == FUNC_PALETTE) || (!is_pad && emits));
        push_entry.depth_log = depth_log;
        push_entry.column    = col_reg;
        push_entry.row       = row_reg;
        push_entry.done      = done;
        if (func == FUNC_PALETTE) begin
            push_entry.kind  = ENT_PAL_WRITE;
            push_entry.color = palette_color;
            push_entry.code  = palette_index;
            push_entry.count = COUNT_W'(1);
        end else if (sub_mode) begin
            push_entry.kind  = ENT_INDEXED;
            push_entry.color = gathered;
            push_entry.code  = data_byte;
            push_entry.count = sub_count;
        end else begin
            push_entry.kind  = ENT_DIRECT;
            push_entry.color = gathered;
            push_entry.code  = data_byte;
            push_entry.count = COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            rbc_reg    <= '0;
            bip_reg    <= '0;
            gather_reg <= '0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            rbc_reg    <= rbc_next;
            bip_reg    <= bip_next;
            gather_reg <= gather_next;
        end
    end

endmodule

// ----- sv/bpu_queue.sv -----
// Short queue of classified entries between the front and the back end.
`timescale 1ns / 1ps

module bpu_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  bpu_pkg::bpu_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output bpu_pkg::bpu_entry_t pop_entry
);
    import bpu_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bpu_entry_t       slot_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- sv/bpu_back.sv -----
// Back end: expands entries into pixels, owns the palette, drives the output register.
`timescale 1ns / 1ps

module bpu_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  bpu_pkg::bpu_entry_t         pop_entry,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bpu_pkg::COLOR_W-1:0] pixel_color,
    output logic [bpu_pkg::COORD_W-1:0] pixel_column,
    output logic [bpu_pkg::COORD_W-1:0] pixel_row,
    output logic                        last_of_byte,
    output logic                        image_done
);
    import bpu_pkg::*;

    logic [COLOR_W-1:0]    palette_mem [PAL_DEPTH];
    logic [COLOR_W-1:0]    rd_data_reg;

    logic [2:0]            k_reg, k_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  direct_reg;
    logic [COLOR_W-1:0]    direct_color_reg;
    logic [COORD_W-1:0]    col_out_reg;
    logic [COORD_W-1:0]    row_out_reg;
    logic                  last_out_reg;
    logic                  done_out_reg;

    logic                  issue_ok;
    logic                  step;
    logic                  is_write;
    logic                  k_last;
    logic                  emit;
    logic [2:0]            bit_shift;
    logic [COUNT_W-1:0]    bits;
    logic [7:0]            shifted;
    logic [PAL_ADDR_W-1:0] idx;

    // Decide what the head entry does this cycle
    always_comb begin
        issue_ok = !out_valid_reg || m_ready;
        step     = pop_valid && issue_ok;
        unique case (pop_entry.kind)
            ENT_PAL_WRITE: is_write = 1'b1;
            ENT_INDEXED:   is_write = 1'b0;
            ENT_DIRECT:    is_write = 1'b0;
            default:       is_write = 1'b1;
        endcase
        k_last    = (({1'b0, k_reg} + COUNT_W'(1)) == pop_entry.count);
        emit      = step && !is_write;
        pop_ready = step && (is_write || k_last);
        k_next    = k_reg;
        if (emit) begin
            k_next = k_last ? '0 : k_reg + 3'd1;
        end
        // Select the k-th index of the byte, most significant first
        bit_shift = 3'(k_reg << pop_entry.depth_log);
        bits      = COUNT_W'(4'd1 << pop_entry.depth_log);
        shifted   = pop_entry.code << bit_shift;
        idx       = PAL_ADDR_W'(shifted >> (COUNT_W'(8) - bits));
        out_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    // Palette store and registered lookup
    always_ff @(posedge aclk) begin
        if (step && is_write) begin
            palette_mem[pop_entry.code] <= pop_entry.color;
        end
        if (emit) begin
            rd_data_reg <= palette_mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output register with the pixel metadata
    always_ff @(posedge aclk) begin
        if (emit) begin
            direct_reg       <= (pop_entry.kind == ENT_DIRECT);
            direct_color_reg <= pop_entry.color;
            col_out_reg      <= pop_entry.column + COORD_W'(k_reg);
            row_out_reg      <= pop_entry.row;
            last_out_reg     <= k_last;
            done_out_reg     <= pop_entry.done && k_last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign pixel_color  = direct_reg ? direct_color_reg : rd_data_reg;
    assign pixel_column = col_out_reg;
    assign pixel_row    = row_out_reg;
    assign last_of_byte = last_out_reg;
    assign image_done   = done_out_reg;

endmodule
